@@ rtl/core/fir_rc_pkg.sv @@
// Shared types and constants for the real/complex FIR filter.
`timescale 1ns / 1ps

package fir_rc_pkg;

  // Sample and tap format: signed Q1.15
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = SAMPLE_W - 1;
  localparam int TAP_IDX_W = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Operation codes; code 3 is accepted and ignored
  typedef enum logic [1:0] {
    OP_LOAD_TAP = 2'd0,
    OP_REAL     = 2'd1,
    OP_CPLX     = 2'd2
  } opcode_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [TAP_IDX_W-1:0]   tap_index;
    sample_t                tap_value;
    sample_t                sample_re;
    sample_t                sample_im;
    logic                   last_in_block;
  } in_t;

  typedef struct packed {
    sample_t out_re;
    sample_t out_im;
    logic    is_complex;
    logic    block_end;
  } out_t;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic shift_real;  // shift a new real sample down the real line
    logic shift_cplx;  // shift a new complex sample down both complex lines
    logic sel_cplx;    // accumulate the complex lines instead of the real line
  } cell_ctl_t;

endpackage

@@ rtl/core/fir_filter_real_complex.sv @@
// Direct-form FIR filter with real taps, a real delay line and a complex delay line.
//
// Each transfer carries an opcode: a tap load writes one coefficient and gives no
// result; a real or complex sample shifts into its own delay line (both clear at
// reset) and gives one result. A sample holds off the next item until its result is
// in the output register: after the shift, a partial sum walks down the chain of
// NTAPS tap cells, one cell per cycle, each adding its product; the sum is then rounded,
// shifted right by 15 and saturated into the output register. Real and imaginary parts
// are accumulated side by side in the same walk. A result waiting in the output
// register on out_stall_i does not hold off the next input item; a finished result
// that finds the output register still stalled is parked, and the input stays stalled
// until the parked result moves up into the output register.
// Taps must be loaded before they are used; an unloaded tap gives an undefined output.
`timescale 1ns / 1ps

module fir_filter_real_complex #(
  parameter int NTAPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fir_rc_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fir_rc_pkg::out_t   out_data_o
);
  import fir_rc_pkg::*;

  // Largest sum is NTAPS * 2^30, which fits in this signed width
  localparam int ACC_W = 2 * SAMPLE_W + $clog2(NTAPS);

  logic      accept;
  logic      load_en;
  cell_ctl_t ctl;
  logic      busy_q, start_q, cplx_q, last_q;
  logic      pend_valid_q, out_valid_q;
  out_t      pend_q, out_q;
  out_t      res;
  logic      out_free;
  logic      done;
  sample_t   rnd_re, rnd_im;

  logic [NTAPS-1:0] tap_we;
  sample_t          real_c [NTAPS];
  sample_t          cre_c  [NTAPS];
  sample_t          cim_c  [NTAPS];
  logic [NTAPS:0]   vld_c;
  logic signed [ACC_W-1:0] acc_re_c [NTAPS+1];
  logic signed [ACC_W-1:0] acc_im_c [NTAPS+1];

  // Input decode
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_comb begin
    load_en        = 1'b0;
    ctl.shift_real = 1'b0;
    ctl.shift_cplx = 1'b0;
    unique case (in_data_i.opcode)
      OP_LOAD_TAP: load_en        = accept;
      OP_REAL:     ctl.shift_real = accept;
      OP_CPLX:     ctl.shift_cplx = accept;
      default:     ;
    endcase
    ctl.sel_cplx = cplx_q;
  end

  // Tap write enables; an index past the chain matches no cell
  for (genvar i = 0; i < NTAPS; i++) begin : g_we
    assign tap_we[i] = load_en && (32'(in_data_i.tap_index) == 32'(i));
  end

  // Head of the sum wave
  assign vld_c[0]    = start_q;
  assign acc_re_c[0] = '0;
  assign acc_im_c[0] = '0;

  // Cell chain
  for (genvar i = 0; i < NTAPS; i++) begin : g_cell
    sample_t real_in, cre_in, cim_in;
    if (i == 0) begin : g_head
      assign real_in = in_data_i.sample_re;
      assign cre_in  = in_data_i.sample_re;
      assign cim_in  = in_data_i.sample_im;
    end else begin : g_link
      assign real_in = real_c[i-1];
      assign cre_in  = cre_c[i-1];
      assign cim_in  = cim_c[i-1];
    end

    fir_rc_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .tap_we_i    (tap_we[i]),
      .tap_i       (in_data_i.tap_value),
      .real_i      (real_in),
      .cre_i       (cre_in),
      .cim_i       (cim_in),
      .real_o      (real_c[i]),
      .cre_o       (cre_c[i]),
      .cim_o       (cim_c[i]),
      .acc_valid_i (vld_c[i]),
      .acc_re_i    (acc_re_c[i]),
      .acc_im_i    (acc_im_c[i]),
      .acc_valid_o (vld_c[i+1]),
      .acc_re_o    (acc_re_c[i+1]),
      .acc_im_o    (acc_im_c[i+1])
    );
  end

  // Rounding and saturation of the finished sums
  fir_rc_rnd #(.ACC_W (ACC_W)) u_rnd_re (.acc_i (acc_re_c[NTAPS]), .res_o (rnd_re));
  fir_rc_rnd #(.ACC_W (ACC_W)) u_rnd_im (.acc_i (acc_im_c[NTAPS]), .res_o (rnd_im));

  assign done = vld_c[NTAPS];

  always_comb begin
    res.out_re     = rnd_re;
    res.out_im     = cplx_q ? rnd_im : '0;
    res.is_complex = cplx_q;
    res.block_end  = last_q;
  end

  // Item control and output transfer
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      cplx_q       <= 1'b0;
      last_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_q <= ctl.shift_real || ctl.shift_cplx;
      if (ctl.shift_real || ctl.shift_cplx) begin
        busy_q <= 1'b1;
        cplx_q <= ctl.shift_cplx;
        last_q <= in_data_i.last_in_block;
      end
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
          busy_q       <= 1'b0;
        end else if (done) begin
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (done) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (done) begin
        out_q <= res;
      end
    end else if (done) begin
      pend_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Only one sum wave is ever in flight
  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_c))
    else $error("more than one sum wave in the cell chain");

  // A wave only runs while an item is held
  a_wave_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q && !pend_valid_q)
    else $error("sum wave finished without an item in flight");

  // A parked result only exists behind a stalled output
  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q && busy_q)
    else $error("parked result without a full output register");

  // A sample transfer launches the wave in the next cycle
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.shift_real || ctl.shift_cplx) |=> start_q && busy_q)
    else $error("sample transfer did not start a sum wave");

endmodule

@@ rtl/core/fir_rc_cell.sv @@
// One tap cell: tap register, three delay elements and a multiply-accumulate stage.
`timescale 1ns / 1ps

module fir_rc_cell #(
  parameter int ACC_W = 37
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fir_rc_pkg::cell_ctl_t                 ctl_i,
  input  logic                                  tap_we_i,
  input  logic signed [fir_rc_pkg::SAMPLE_W-1:0] tap_i,
  // delay line links
  input  logic signed [fir_rc_pkg::SAMPLE_W-1:0] real_i,
  input  logic signed [fir_rc_pkg::SAMPLE_W-1:0] cre_i,
  input  logic signed [fir_rc_pkg::SAMPLE_W-1:0] cim_i,
  output logic signed [fir_rc_pkg::SAMPLE_W-1:0] real_o,
  output logic signed [fir_rc_pkg::SAMPLE_W-1:0] cre_o,
  output logic signed [fir_rc_pkg::SAMPLE_W-1:0] cim_o,
  // partial sum wave
  input  logic                                  acc_valid_i,
  input  logic signed [ACC_W-1:0]               acc_re_i,
  input  logic signed [ACC_W-1:0]               acc_im_i,
  output logic                                  acc_valid_o,
  output logic signed [ACC_W-1:0]               acc_re_o,
  output logic signed [ACC_W-1:0]               acc_im_o
);
  import fir_rc_pkg::*;

  sample_t tap_q;
  sample_t real_q, cre_q, cim_q;
  sample_t sel_re;
  logic signed [2*SAMPLE_W-1:0] prod_re, prod_im;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic acc_valid_q;

  // Tap coefficient, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_q <= tap_i;
    end
  end

  // Delay elements, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_q <= '0;
      cre_q  <= '0;
      cim_q  <= '0;
    end else begin
      if (ctl_i.shift_real) begin
        real_q <= real_i;
      end
      if (ctl_i.shift_cplx) begin
        cre_q <= cre_i;
        cim_q <= cim_i;
      end
    end
  end

  // Products for this tap
  assign sel_re  = ctl_i.sel_cplx ? cre_q : real_q;
  assign prod_re = sel_re * tap_q;
  assign prod_im = cim_q * tap_q;

  // Add into the passing partial sums; range never exceeds ACC_W
  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_i + ACC_W'(prod_re);
    acc_im_q <= acc_im_i + ACC_W'(prod_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else begin
      acc_valid_q <= acc_valid_i;
    end
  end

  assign real_o      = real_q;
  assign cre_o       = cre_q;
  assign cim_o       = cim_q;
  assign acc_valid_o = acc_valid_q;
  assign acc_re_o    = acc_re_q;
  assign acc_im_o    = acc_im_q;

endmodule

@@ rtl/core/fir_rc_rnd.sv @@
// Round half up, drop the fraction bits and saturate a sum to sample width.
`timescale 1ns / 1ps

module fir_rc_rnd #(
  parameter int ACC_W = 37
) (
  input  logic signed [ACC_W-1:0]                acc_i,
  output logic signed [fir_rc_pkg::SAMPLE_W-1:0] res_o
);
  import fir_rc_pkg::*;

  localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W:0] MAXV = (ACC_W+1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W:0] MINV = -MAXV - (ACC_W+1)'(1);

  logic signed [ACC_W:0] rounded;
  logic signed [ACC_W:0] quot;

  // Arithmetic shift gives floor for negative sums too
  assign rounded = (ACC_W+1)'(acc_i) + HALF;
  assign quot    = rounded >>> FRAC_W;

  always_comb begin
    if (quot > MAXV) begin
      res_o = SAMPLE_W'(MAXV);
    end else if (quot < MINV) begin
      res_o = SAMPLE_W'(MINV);
    end else begin
      res_o = SAMPLE_W'(quot);
    end
  end

endmodule
